[hdl/annealing_metropolis_acceptor_core_assert.svh]
// Assertion shorthands used by the checker file.
`ifndef ANNEALING_METROPOLIS_ACCEPTOR_CORE_ASSERT_SVH
`define ANNEALING_METROPOLIS_ACCEPTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMACC_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMACC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/amacc_pkg.sv]
package amacc_pkg;

  localparam int CostBits    = 32;
  localparam int QBits       = 16;
  localparam int CntBits     = 16;
  localparam int TempBits    = 32;
  localparam int CoolBits    = 16;
  localparam int RndBits     = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;

  localparam int DeltaW   = CostBits + 1;
  localparam int CmpW     = (DeltaW > TempBits + QBits) ? DeltaW : TempBits + QBits;
  localparam int LogeBits = 17;
  localparam logic [LogeBits-1:0] Log2eQ16 = 17'd94548;

  localparam int DivBitsPerCycle = 2;
  localparam int DivCycles       = TempBits / DivBitsPerCycle;
  localparam int DivCntBits      = $clog2(DivCycles);

  localparam int QDepth  = 2;
  localparam int PtrBits = $clog2(QDepth);

  localparam logic [CntBits-1:0] CntMax = '1;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgMaximize  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgFirstTemp = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgCooling   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgReps      = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgMaxLevels = 3'd4;

  localparam logic [TempBits-1:0] RstFirstTemp = 32'd6554;
  localparam logic [CoolBits-1:0] RstCooling   = 16'd58982;
  localparam logic [CntBits-1:0]  RstReps      = 16'd1024;
  localparam logic [CntBits-1:0]  RstMaxLevels = 16'd1000;

  typedef enum logic {
    OpStart = 1'b0,
    OpCand  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [CostBits-1:0] cost;
    logic [RndBits-1:0]         rnd;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic                maximize;
    logic [TempBits-1:0] first_temp;
    logic [CoolBits-1:0] cooling;
    logic [CntBits-1:0]  reps;
    logic [CntBits-1:0]  max_levels;
  } cfg_t;

  // 2^(-k/16) in Q1.16, k = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

[hdl/amacc_if.sv]
interface amacc_in_if;
  import amacc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [CostBits-1:0] cost;
  logic [RndBits-1:0]         random_fraction;
  modport source(output valid, cmd, cost, random_fraction, input ready);
  modport sink(input valid, cmd, cost, random_fraction, output ready);
endinterface

interface amacc_out_if;
  import amacc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic                       new_best;
  logic signed [CostBits-1:0] current_out;
  logic signed [CostBits-1:0] best_out;
  logic [CntBits-1:0]         level_out;
  logic                       finished;
  modport source(output valid, accepted, new_best, current_out, best_out, level_out,
                 finished, input ready);
  modport sink(input valid, accepted, new_best, current_out, best_out, level_out,
               finished, output ready);
endinterface

interface amacc_cfg_if;
  import amacc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/amacc_front.sv]
module amacc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  amacc_in_if.sink          in_i,
  output amacc_pkg::q_push_t push_o,
  input  logic              push_ready_i
);
  import amacc_pkg::*;

  logic  full_q, full_d;
  item_t item_q, item_d;

  assign in_i.ready = !full_q || push_ready_i;
  assign push_o.valid = full_q;
  assign push_o.item  = item_q;

  always_comb begin
    full_d = full_q;
    item_d = item_q;
    if (full_q && push_ready_i) begin
      full_d = 1'b0;
    end
    if (in_i.valid && in_i.ready) begin
      full_d      = 1'b1;
      // classify: start of a run or a candidate
      item_d.op   = in_i.cmd ? OpCand : OpStart;
      item_d.cost = in_i.cost;
      item_d.rnd  = in_i.random_fraction;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

[hdl/amacc_queue.sv]
module amacc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amacc_pkg::q_push_t push_i,
  output logic               push_ready_o,
  output amacc_pkg::q_push_t head_o,
  input  logic               pop_i
);
  import amacc_pkg::*;

  item_t              mem_q [QDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   count_q, count_d;
  logic               wr_en, rd_en;

  assign push_ready_o = (count_q != (PtrBits+1)'(QDepth));
  assign wr_en        = push_i.valid && push_ready_o;
  assign rd_en        = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

[hdl/amacc_back.sv]
module amacc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amacc_pkg::cfg_t    cfg_i,
  input  amacc_pkg::q_push_t head_i,
  output logic               pop_o,
  amacc_out_if.source        out_o
);
  import amacc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPre  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StExp  = 3'd4;
  localparam logic [2:0] StDec  = 3'd5;
  localparam logic [2:0] StCool = 3'd6;

  logic [2:0] state_q, state_d;

  logic signed [CostBits-1:0] cur_q, cur_d, best_q, best_d, cost_q, cost_d;
  logic [TempBits-1:0]        temp_q, temp_d;
  logic [CntBits-1:0]         rep_q, rep_d, lvl_q, lvl_d, chg_q, chg_d;
  logic                       run_q, run_d;

  logic [DeltaW-1:0]     delta_q, delta_d;
  logic [RndBits-1:0]    rnd_q, rnd_d;
  logic [TempBits:0]     rem_q, rem_d;
  logic [TempBits-1:0]   dsh_q, dsh_d, quo_q, quo_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [TempBits:0]     y_q, y_d;
  logic                  acc_q, acc_d;

  logic                       ov_q, ov_d, oacc_q, oacc_d, onb_q, onb_d, ofin_q, ofin_d;
  logic signed [CostBits-1:0] ocur_q, ocur_d, obest_q, obest_d;
  logic [CntBits-1:0]         olvl_q, olvl_d;

  logic                  out_free;
  logic [DeltaW-1:0]     hi_e, lo_e, diff;
  logic [DeltaW+QBits-1:0] dividend;
  logic                  over;
  logic [TempBits:0]     r_w;
  logic [TempBits-1:0]   d_w, q_w;
  logic [TempBits+LogeBits-1:0] prod_y;
  logic [TempBits-QBits:0] n_w;
  logic [16:0]           p0, p1, v_w, omega;
  logic [28:0]           prod_i;
  logic [TempBits+CoolBits-1:0] prod_t;
  logic signed [CostBits-1:0] cand;
  logic                  better, lvl_end;
  logic [CntBits-1:0]    reps_eff, rep_n, lvl_n, chg_n;

  assign out_free        = !ov_q || out_o.ready;
  assign out_o.valid     = ov_q;
  assign out_o.accepted  = oacc_q;
  assign out_o.new_best  = onb_q;
  assign out_o.current_out = ocur_q;
  assign out_o.best_out  = obest_q;
  assign out_o.level_out = olvl_q;
  assign out_o.finished  = ofin_q;

  // worsening of the queued candidate against the current cost; StIdle clamps it at zero when storing it
  assign hi_e = cfg_i.maximize ? {cur_q[CostBits-1], cur_q}
                               : {head_i.item.cost[CostBits-1], head_i.item.cost};
  assign lo_e = cfg_i.maximize ? {head_i.item.cost[CostBits-1], head_i.item.cost}
                               : {cur_q[CostBits-1], cur_q};
  assign diff = hi_e - lo_e;

  assign dividend = {delta_q, {QBits{1'b0}}};
  assign over     = CmpW'(delta_q) >= (CmpW'(temp_q) << QBits);
  assign prod_y   = quo_q * Log2eQ16;
  assign n_w      = y_q[TempBits:QBits];
  assign p0       = pow2_neg({1'b0, y_q[15:12]});
  assign p1       = pow2_neg({1'b0, y_q[15:12]} + 5'd1);
  assign prod_i   = (p0 - p1) * y_q[11:0];
  assign v_w      = p0 - 17'(prod_i >> 12);
  assign omega    = (n_w >= (TempBits-QBits+1)'(17)) ? '0 : v_w >> n_w[4:0];
  assign prod_t   = temp_q * cfg_i.cooling;
  assign cand     = cost_q;
  assign better   = cfg_i.maximize ? (cand > best_q) : (best_q > cand);
  assign reps_eff = (cfg_i.reps == '0) ? CntBits'(1) : cfg_i.reps;

  always_comb begin
    state_d = state_q;
    cur_d = cur_q; best_d = best_q; cost_d = cost_q; temp_d = temp_q;
    rep_d = rep_q; lvl_d = lvl_q; chg_d = chg_q; run_d = run_q;
    delta_d = delta_q; rnd_d = rnd_q; rem_d = rem_q; dsh_d = dsh_q; quo_d = quo_q;
    cnt_d = cnt_q; y_d = y_q; acc_d = acc_q;
    ov_d = ov_q; oacc_d = oacc_q; onb_d = onb_q; ofin_d = ofin_q;
    ocur_d = ocur_q; obest_d = obest_q; olvl_d = olvl_q;
    pop_o = 1'b0;
    r_w = rem_q; d_w = dsh_q; q_w = quo_q;
    rep_n = rep_q; lvl_n = lvl_q; chg_n = chg_q; lvl_end = 1'b0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          if (head_i.item.op == OpStart) begin
            cur_d  = head_i.item.cost;
            best_d = head_i.item.cost;
            temp_d = cfg_i.first_temp;
            rep_d  = '0;
            lvl_d  = '0;
            chg_d  = '0;
            run_d  = (cfg_i.max_levels != '0);
            ov_d = 1'b1; oacc_d = 1'b0; onb_d = 1'b0;
            ocur_d = head_i.item.cost; obest_d = head_i.item.cost;
            olvl_d = '0; ofin_d = (cfg_i.max_levels == '0);
          end else if (!run_q) begin
            ov_d = 1'b1; oacc_d = 1'b0; onb_d = 1'b0;
            ocur_d = cur_q; obest_d = best_q; olvl_d = lvl_q; ofin_d = 1'b1;
          end else begin
            delta_d = ($signed(hi_e) > $signed(lo_e)) ? diff : '0;
            cost_d  = head_i.item.cost;
            rnd_d   = head_i.item.rnd;
            state_d = StPre;
          end
        end
      end
      StPre: begin
        if (delta_q == '0) begin
          acc_d   = 1'b1;
          state_d = StDec;
        end else if (temp_q == '0 || over) begin
          quo_d   = '1;
          state_d = StMul;
        end else begin
          rem_d   = {1'b0, TempBits'(dividend >> TempBits)};
          dsh_d   = dividend[TempBits-1:0];
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        for (int i = 0; i < DivBitsPerCycle; i++) begin
          r_w = {r_w[TempBits-1:0], d_w[TempBits-1]};
          d_w = d_w << 1;
          if (r_w >= {1'b0, temp_q}) begin
            r_w = r_w - {1'b0, temp_q};
            q_w = {q_w[TempBits-2:0], 1'b1};
          end else begin
            q_w = {q_w[TempBits-2:0], 1'b0};
          end
        end
        rem_d = r_w;
        dsh_d = d_w;
        quo_d = q_w;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntBits'(DivCycles-1)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        y_d     = prod_y[TempBits+QBits:QBits];
        state_d = StExp;
      end
      StExp: begin
        acc_d   = ({1'b0, rnd_q} < omega);
        state_d = StDec;
      end
      StDec: begin
        if (out_free) begin
          onb_d = 1'b0;
          if (acc_q) begin
            cur_d = cand;
            if (better) begin
              best_d = cand;
              onb_d  = 1'b1;
            end
            chg_n = (chg_q != CntMax) ? chg_q + 1'b1 : chg_q;
          end
          rep_n = rep_q + 1'b1;
          lvl_end = (rep_n >= reps_eff);
          if (lvl_end) begin
            rep_n = '0;
            lvl_n = (lvl_q != CntMax) ? lvl_q + 1'b1 : lvl_q;
            if (chg_n == '0 || lvl_n >= cfg_i.max_levels) begin
              run_d = 1'b0;
            end
            chg_n   = '0;
            state_d = StCool;
          end else begin
            state_d = StIdle;
          end
          rep_d = rep_n;
          lvl_d = lvl_n;
          chg_d = chg_n;
          ov_d  = 1'b1;
          oacc_d = acc_q;
          ocur_d = acc_q ? cand : cur_q;
          obest_d = (acc_q && better) ? cand : best_q;
          olvl_d = lvl_n;
          ofin_d = !run_d;
        end
      end
      StCool: begin
        temp_d  = prod_t[TempBits+CoolBits-1:CoolBits];
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_q   <= '0;
      best_q  <= '0;
      temp_q  <= '0;
      rep_q   <= '0;
      lvl_q   <= '0;
      chg_q   <= '0;
      run_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      best_q  <= best_d;
      temp_q  <= temp_d;
      rep_q   <= rep_d;
      lvl_q   <= lvl_d;
      chg_q   <= chg_d;
      run_q   <= run_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    cost_q  <= cost_d;
    rnd_q   <= rnd_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    oacc_q  <= oacc_d;
    onb_q   <= onb_d;
    ofin_q  <= ofin_d;
    ocur_q  <= ocur_d;
    obest_q <= obest_d;
    olvl_q  <= olvl_d;
  end

endmodule

[hdl/annealing_metropolis_acceptor_core.sv]
// Channel   Modport              Payload
// in_i      amacc_in_if.sink     cmd, cost, random_fraction
// out_o     amacc_out_if.source  accepted, new_best, current_out, best_out, level_out, finished
// cfg_i     amacc_cfg_if.sink    index, data (always ready)
//
// A start item or a candidate after the run has stopped is answered from the idle state.
// A candidate with zero worsening goes through the pre and decision states; one whose
// quotient saturates (zero temperature or worsening too large) skips the divider; any other
// runs the radix-4 divider, then one multiply, one exp step and one decision.
// The last candidate of a level adds a step for the cooling multiply.
// The front register and a two-entry queue take new items while the back end works
// or its result waits; reset clears state and counters, with no clearing pass.
module annealing_metropolis_acceptor_core (
  input logic          clk_i,
  input logic          rst_ni,
  amacc_in_if.sink     in_i,
  amacc_out_if.source  out_o,
  amacc_cfg_if.sink    cfg_i
);
  import amacc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_push_t push, head;
  logic    push_ready, pop;

  // configuration is always taken; unknown indexes drop silently
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMaximize:  cfg_d.maximize   = cfg_i.data[0];
        CfgFirstTemp: cfg_d.first_temp = cfg_i.data[TempBits-1:0];
        CfgCooling:   cfg_d.cooling    = cfg_i.data[CoolBits-1:0];
        CfgReps:      cfg_d.reps       = cfg_i.data[CntBits-1:0];
        CfgMaxLevels: cfg_d.max_levels = cfg_i.data[CntBits-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.maximize   <= 1'b0;
      cfg_q.first_temp <= RstFirstTemp;
      cfg_q.cooling    <= RstCooling;
      cfg_q.reps       <= RstReps;
      cfg_q.max_levels <= RstMaxLevels;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // accept and classify
  amacc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // decouple front and back
  amacc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Metropolis decision and cooling
  amacc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

[hdl/amacc_checker.sv]
`include "annealing_metropolis_acceptor_core_assert.svh"

module amacc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic                                 accepted_i,
  input logic                                 new_best_i,
  input logic signed [amacc_pkg::CostBits-1:0] current_i,
  input logic signed [amacc_pkg::CostBits-1:0] best_i
);
  import amacc_pkg::*;

  `AMACC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result transaction dropped while stalled")
  `AMACC_ASSERT_NOW(a_best_acc, clk_i, rst_ni, out_valid_i && new_best_i, accepted_i, "new best without acceptance")
  `AMACC_ASSERT_NOW(a_best_cur, clk_i, rst_ni, out_valid_i && new_best_i, best_i == current_i, "new best differs from current cost")

endmodule

bind annealing_metropolis_acceptor_core amacc_checker u_amacc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .accepted_i  (out_o.accepted),
  .new_best_i  (out_o.new_best),
  .current_i   (out_o.current_out),
  .best_i      (out_o.best_out)
);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import amacc_pkg::*;

  // Q1.16 samples of 2^(-k/16), k = 0..16, for the exp approximation
  localparam int unsigned EXP2_TBL [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };
  localparam longint unsigned LOG2E_Q16 = 94548;
  localparam longint unsigned Q_SAT     = 64'hFFFF_FFFF;
  localparam int NUM_PHASES = 10;
  localparam int SETTLE     = 40;

  typedef struct packed {
    logic                accepted;
    logic                new_best;
    logic signed [31:0]  current_cost;
    logic signed [31:0]  best_cost;
    logic [15:0]         level;
    logic                finished;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  amacc_in_if  in_if();
  amacc_out_if out_if();
  amacc_cfg_if cfg_if();

  annealing_metropolis_acceptor_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predictor state: register copies and annealing state
  logic               reg_maximize;
  logic [31:0]        reg_first_temp;
  logic [15:0]        reg_cooling;
  logic [15:0]        reg_reps;
  logic [15:0]        reg_max_levels;
  logic signed [31:0] cur_cost;
  logic signed [31:0] best_cost;
  logic [31:0]        temperature;
  logic [15:0]        rep_cnt;
  logic [15:0]        level_cnt;
  logic [15:0]        level_changes;
  logic               running;

  item_t    pending_items[$];
  verdict_t expected_verdicts[$];
  int       n_sent;
  int       n_taken;
  int       send_gap;
  int       ready_gap;
  bit       no_idle;
  int       fail_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run, far above the slowest legal schedule
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Metropolis threshold: Q1.16 approximation of exp(-delta/T)
  function automatic int unsigned accept_threshold(longint unsigned delta, logic [31:0] t);
    longint unsigned q;
    longint unsigned y;
    longint unsigned n;
    int unsigned     f;
    int unsigned     idx;
    int unsigned     r;
    int unsigned     v;
    if (t == 0) begin
      q = Q_SAT;
    end else begin
      q = (delta << 16) / t;
      if (q > Q_SAT) q = Q_SAT;
    end
    y = (q * LOG2E_Q16) >> 16;
    n = y >> 16;
    if (n >= 17) return 0;
    f   = int'(y & 64'hFFFF);
    idx = f >> 12;
    r   = f & 12'hFFF;
    v   = EXP2_TBL[idx] - (((EXP2_TBL[idx] - EXP2_TBL[idx + 1]) * r) >> 12);
    return v >> n;
  endfunction

  // Advance the annealing state by one transaction and return what the block reports
  function automatic verdict_t anneal_step(item_t it);
    verdict_t        v;
    longint          hi;
    longint          lo;
    longint unsigned delta;
    logic [15:0]     reps;
    v = '0;
    if (it.op == OpStart) begin
      cur_cost      = it.cost;
      best_cost     = it.cost;
      temperature   = reg_first_temp;
      rep_cnt       = '0;
      level_cnt     = '0;
      level_changes = '0;
      running       = (reg_max_levels != 0);
    end else if (running) begin
      hi    = reg_maximize ? longint'(cur_cost) : longint'(it.cost);
      lo    = reg_maximize ? longint'(it.cost) : longint'(cur_cost);
      delta = (hi > lo) ? longint'(hi - lo) : 0;
      reps  = (reg_reps != 0) ? reg_reps : 16'd1;
      if (delta == 0 || it.rnd < accept_threshold(delta, temperature)) v.accepted = 1'b1;
      if (v.accepted) begin
        cur_cost = it.cost;
        if (reg_maximize ? (it.cost > best_cost) : (best_cost > it.cost)) begin
          best_cost  = it.cost;
          v.new_best = 1'b1;
        end
        if (level_changes != CntMax) level_changes++;
      end
      rep_cnt = rep_cnt + 16'd1;
      if (rep_cnt >= reps) begin
        rep_cnt     = '0;
        temperature = 32'((64'(temperature) * reg_cooling) >> 16);
        if (level_cnt != CntMax) level_cnt++;
        if (level_changes == 0 || level_cnt >= reg_max_levels) running = 1'b0;
        level_changes = '0;
      end
    end
    v.current_cost = cur_cost;
    v.best_cost    = best_cost;
    v.level        = level_cnt;
    v.finished     = ~running;
    return v;
  endfunction

  // Track input and config transactions at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_maximize   <= 1'b0;
      reg_first_temp <= RstFirstTemp;
      reg_cooling    <= RstCooling;
      reg_reps       <= RstReps;
      reg_max_levels <= RstMaxLevels;
      cur_cost       <= '0;
      best_cost      <= '0;
      temperature    <= '0;
      rep_cnt        <= '0;
      level_cnt      <= '0;
      level_changes  <= '0;
      running        <= 1'b0;
      n_taken        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        item_t it;
        it.op   = op_e'(in_if.cmd);
        it.cost = in_if.cost;
        it.rnd  = in_if.random_fraction;
        expected_verdicts.push_back(anneal_step(it));
        n_taken <= n_taken + 1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgMaximize:  reg_maximize   <= cfg_if.data[0];
          CfgFirstTemp: reg_first_temp <= cfg_if.data;
          CfgCooling:   reg_cooling    <= cfg_if.data[15:0];
          CfgReps:      reg_reps       <= cfg_if.data[15:0];
          CfgMaxLevels: reg_max_levels <= cfg_if.data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Driver: hold the current item until taken, then gap or advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && n_taken < n_sent) begin
      // hold
    end else if (send_gap > 0) begin
      in_if.valid <= 1'b0;
      send_gap--;
    end else if (pending_items.size() > 0) begin
      item_t it;
      it = pending_items.pop_front();
      in_if.valid           <= 1'b1;
      in_if.cmd             <= it.op;
      in_if.cost            <= it.cost;
      in_if.random_fraction <= it.rnd;
      n_sent++;
      send_gap = no_idle ? 0 : pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Result-side backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      out_if.ready <= 1'b0;
      ready_gap--;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 5) == 0) ready_gap = pick_gap();
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      verdict_t e;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        fail_cnt++;
      end else begin
        e = expected_verdicts.pop_front();
        if (out_if.accepted !== e.accepted) begin
          $display("%0t: accepted exp %0d got %0d", $time, e.accepted, out_if.accepted);
          fail_cnt++;
        end
        if (out_if.new_best !== e.new_best) begin
          $display("%0t: new_best exp %0d got %0d", $time, e.new_best, out_if.new_best);
          fail_cnt++;
        end
        if (out_if.current_out !== e.current_cost) begin
          $display("%0t: current_out exp %h got %h", $time, e.current_cost,
                   out_if.current_out);
          fail_cnt++;
        end
        if (out_if.best_out !== e.best_cost) begin
          $display("%0t: best_out exp %h got %h", $time, e.best_cost, out_if.best_out);
          fail_cnt++;
        end
        if (out_if.level_out !== e.level) begin
          $display("%0t: level_out exp %0d got %0d", $time, e.level, out_if.level_out);
          fail_cnt++;
        end
        if (out_if.finished !== e.finished) begin
          $display("%0t: finished exp %0d got %0d", $time, e.finished, out_if.finished);
          fail_cnt++;
        end
      end
    end
  end

  task automatic add_item(op_e op, logic signed [31:0] cost, logic [15:0] rnd);
    item_t it;
    it.op   = op;
    it.cost = cost;
    it.rnd  = rnd;
    pending_items.push_back(it);
  endtask

  // Block until every queued transaction has been taken and answered, then settle
  task automatic drain();
    while (pending_items.size() > 0 || n_taken < n_sent || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(logic maxi, logic [31:0] t0, logic [15:0] cool,
                           logic [15:0] reps, logic [15:0] lvls);
    write_reg(CfgMaximize, {31'd0, maxi});
    write_reg(CfgFirstTemp, t0);
    write_reg(CfgCooling, {16'd0, cool});
    write_reg(CfgReps, {16'd0, reps});
    write_reg(CfgMaxLevels, {16'd0, lvls});
  endtask

  // Well-formed runs: a start, then candidates scattered around the start cost
  // on the scale of the temperature; some noise and idle candidates mixed in.
  task automatic fill_runs(int n_items, logic [31:0] t0);
    longint span;
    longint base;
    int     left;
    int     len;
    span = (t0 == 0) ? 1000 : longint'(t0) * 3;
    if (span > 64'h4000_0000) span = 64'h4000_0000;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0:       base = longint'($signed($urandom()));
        1:       base = ($urandom_range(0, 1) != 0) ? 64'sh7FFF_FFF0 : -64'sh7FFF_FFF0;
        default: base = longint'($signed($urandom_range(0, 32'h00FF_FFFF))) - 64'sh80_0000;
      endcase
      if ($urandom_range(0, 15) == 0) add_item(OpCand, $urandom(), $urandom());
      add_item(OpStart, 32'(base), $urandom());
      len = $urandom_range(4, 60);
      for (int i = 0; i < len && left > 0; i++, left--) begin
        longint off;
        off = longint'($urandom_range(0, 32'(2 * span))) - span;
        if ($urandom_range(0, 19) == 0) add_item(OpCand, $urandom(), $urandom());
        else if ($urandom_range(0, 9) == 0) add_item(OpCand, 32'(base), $urandom());
        else add_item(OpCand, 32'(base + off), $urandom());
      end
      left--;
    end
  endtask

  initial begin
    logic        p_max;
    logic [31:0] p_t0;
    logic [15:0] p_cool;
    logic [15:0] p_reps;
    logic [15:0] p_lvls;

    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.cmd             = 1'b0;
    in_if.cost            = '0;
    in_if.random_fraction = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    n_sent    = 0;
    send_gap  = 0;
    ready_gap = 0;
    no_idle   = 1'b0;
    fail_cnt  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle candidate, cost extremes, zero worsening, random fraction extremes
    add_item(OpCand, 32'sh0000_1000, 16'h0000);
    add_item(OpStart, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(OpCand, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(OpCand, 32'sh8000_0000, 16'hFFFF);
    add_item(OpCand, 32'sh7FFF_FFFF, 16'h0000);
    add_item(OpCand, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(OpCand, 32'sh8000_0001, 16'h0000);
    add_item(OpCand, 32'sh8000_0000, 16'h0000);
    add_item(OpStart, 32'sh0000_0000, 16'h0000);
    add_item(OpCand, 32'sh0000_0100, 16'h0000);
    add_item(OpCand, 32'sh0000_0100, 16'hFFFF);
    add_item(OpCand, 32'shFFFF_FF00, 16'h8000);
    drain();

    // Maximize direction, a short level, and a zero-temperature run
    write_all(1'b1, 32'd0, 16'd32768, 16'd2, 16'd3);
    add_item(OpStart, 32'sh8000_0000, 16'h1234);
    add_item(OpCand, 32'sh7FFF_FFFF, 16'hFFFF);
    add_item(OpCand, 32'sh7FFF_FFFE, 16'h0000);
    add_item(OpCand, 32'sh7FFF_FFFF, 16'h0000);
    add_item(OpCand, 32'sh0000_0000, 16'h0000);
    add_item(OpCand, 32'sh0000_0000, 16'h0000);
    drain();
    // Zero reps treated as one; zero level limit leaves the block idle
    write_all(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0);
    add_item(OpStart, 32'sh0001_0000, 16'h0000);
    add_item(OpCand, 32'sh0000_0000, 16'h0000);
    drain();
    write_reg(CfgMaxLevels, 32'd2);
    add_item(OpStart, 32'sh0001_0000, 16'h0000);
    add_item(OpCand, 32'sh7FFF_0000, 16'h0000);
    add_item(OpCand, 32'sh0000_0000, 16'h0000);
    add_item(OpCand, 32'sh0000_0000, 16'h0000);
    drain();

    // Random phases through a spread of settings, extremes first
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin p_max = 0; p_t0 = 32'd6554;      p_cool = 16'd58982; p_reps = 4;  p_lvls = 6;     end
        1: begin p_max = 1; p_t0 = 32'd65536;     p_cool = 16'd32768; p_reps = 3;  p_lvls = 10;    end
        2: begin p_max = 0; p_t0 = 32'hFFFF_FFFF; p_cool = 16'hFFFF;  p_reps = 2;  p_lvls = 16'hFFFF; end
        3: begin p_max = 1; p_t0 = 32'd1;         p_cool = 16'd1;     p_reps = 1;  p_lvls = 1;     end
        4: begin p_max = 0; p_t0 = 32'd0;         p_cool = 16'd100;   p_reps = 5;  p_lvls = 3;     end
        5: begin p_max = 1; p_t0 = 32'd200000;    p_cool = 16'd50000; p_reps = 16'hFFFF; p_lvls = 4; end
        default: begin
          p_max  = $urandom_range(0, 1);
          p_t0   = $urandom_range(1, 32'h0100_0000);
          p_cool = $urandom_range(1, 16'hFFFF);
          p_reps = $urandom_range(1, 8);
          p_lvls = $urandom_range(1, 12);
        end
      endcase
      write_all(p_max, p_t0, p_cool, p_reps, p_lvls);
      no_idle = (ph == 2 || ph == 7);
      fill_runs(150, p_t0);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
